@@ sv/lslf_pkg.sv @@
// lslf_pkg: shared types, codes and lookup functions for the link session
// lifecycle controller; no dependencies

package lslf_pkg;

  // event codes carried in req_type
  typedef enum logic [3:0] {
    EV_SESSION_RST = 4'd0,
    EV_PROCEED     = 4'd1,
    EV_FLUSH_DONE  = 4'd2,
    EV_RST_REQ     = 4'd3,
    EV_RST_ACK     = 4'd4,
    EV_DISC_REQ    = 4'd5,
    EV_DISC_ACK    = 4'd6,
    EV_OPEN_ACK    = 4'd7,
    EV_OPEN_NACK   = 4'd8,
    EV_BULK_ACK    = 4'd9,
    EV_BULK_NACK   = 4'd10,
    EV_CLOSE_ACK   = 4'd11,
    EV_API_OPEN    = 4'd12,
    EV_API_CLOSE   = 4'd13
  } lslf_ev_e;

  // action codes
  typedef enum logic [3:0] {
    ACT_NONE       = 4'd0,
    ACT_LL_OPEN    = 4'd1,
    ACT_BULK_OPEN  = 4'd2,
    ACT_RST_REQ    = 4'd3,
    ACT_RST_ACK    = 4'd4,
    ACT_FLUSH_PING = 4'd5,
    ACT_DISC_REQ   = 4'd6,
    ACT_LL_CLOSE   = 4'd7,
    ACT_OPEN_OK    = 4'd8,
    ACT_OPEN_FAIL  = 4'd9,
    ACT_CLOSE_OK   = 4'd10,
    ACT_CLOSE_FAIL = 4'd11
  } lslf_act_e;

  // external state codes reported in state_now
  localparam logic [3:0] SC_INVALID       = 4'd0;
  localparam logic [3:0] SC_NOT_PRESENT   = 4'd1;
  localparam logic [3:0] SC_CLOSED        = 4'd2;
  localparam logic [3:0] SC_LL_OPEN       = 4'd3;
  localparam logic [3:0] SC_LL_BULK_OPEN  = 4'd4;
  localparam logic [3:0] SC_LINK_RESET    = 4'd5;
  localparam logic [3:0] SC_OPEN          = 4'd6;
  localparam logic [3:0] SC_PUBSUB_FLUSH  = 4'd7;
  localparam logic [3:0] SC_LINK_DISC     = 4'd8;
  localparam logic [3:0] SC_LL_CLOSE_PEND = 4'd9;
  localparam logic [3:0] SC_LL_CLOSE      = 4'd10;
  localparam logic [3:0] SC_FINALIZED     = 4'd11;

  // session state, one-hot
  typedef enum logic [11:0] {
    ST_NO_SESSION    = 12'b0000_0000_0001,
    ST_NOT_PRESENT   = 12'b0000_0000_0010,
    ST_IDLE          = 12'b0000_0000_0100,
    ST_LL_OPENING    = 12'b0000_0000_1000,
    ST_BULK_OPENING  = 12'b0000_0001_0000,
    ST_LINK_RESYNC   = 12'b0000_0010_0000,
    ST_OPEN          = 12'b0000_0100_0000,
    ST_PUBSUB_FLUSH  = 12'b0000_1000_0000,
    ST_LINK_DISC     = 12'b0001_0000_0000,
    ST_CLOSE_WAIT    = 12'b0010_0000_0000,
    ST_LL_CLOSING    = 12'b0100_0000_0000,
    ST_DONE          = 12'b1000_0000_0000
  } lslf_state_e;

  typedef struct packed {
    logic [3:0] req_type;
    logic       finalize_request;
  } lslf_req_t;

  typedef struct packed {
    logic [3:0] action;
    logic [3:0] state_now;
  } lslf_rsp_t;

  function automatic logic [3:0] state_code(lslf_state_e st);
    logic [3:0] code;
    case (st)
      ST_NOT_PRESENT:   code = SC_NOT_PRESENT;
      ST_IDLE:          code = SC_CLOSED;
      ST_LL_OPENING:    code = SC_LL_OPEN;
      ST_BULK_OPENING:  code = SC_LL_BULK_OPEN;
      ST_LINK_RESYNC:   code = SC_LINK_RESET;
      ST_OPEN:          code = SC_OPEN;
      ST_PUBSUB_FLUSH:  code = SC_PUBSUB_FLUSH;
      ST_LINK_DISC:     code = SC_LINK_DISC;
      ST_CLOSE_WAIT:    code = SC_LL_CLOSE_PEND;
      ST_LL_CLOSING:    code = SC_LL_CLOSE;
      ST_DONE:          code = SC_FINALIZED;
      default:          code = SC_INVALID;
    endcase
    return code;
  endfunction

  // action issued on entry to a state
  function automatic lslf_act_e entry_action(lslf_state_e st);
    lslf_act_e act;
    case (st)
      ST_LL_OPENING:   act = ACT_LL_OPEN;
      ST_BULK_OPENING: act = ACT_BULK_OPEN;
      ST_LINK_RESYNC:  act = ACT_RST_REQ;
      ST_PUBSUB_FLUSH: act = ACT_FLUSH_PING;
      ST_LINK_DISC:    act = ACT_DISC_REQ;
      ST_LL_CLOSING:   act = ACT_LL_CLOSE;
      default:         act = ACT_NONE;
    endcase
    return act;
  endfunction

endpackage

@@ sv/link_session_lifecycle_fsm_unit.sv @@
// link_session_lifecycle_fsm_unit: top level, input beat register, result
// register and the lifecycle core; depends on lslf_pkg and lslf_core
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------
//   in      | in  | in_valid_i / in_stall_o | in_req_i  (req_type, finalize)
//   out     | out | out_valid_o / out_stall_i | out_rsp_o (action, state_now)
//
// one event per cycle sustained while the output does not stall; an accepted
// beat passes through the input register and then the result register
// the state update happens as a beat moves from the input register into the
// result register, so events are processed strictly in order
// reset puts the session in the invalid state with finalize cleared
// a stall on the output holds the result register, and the input register
// stalls only when it is full and the result register cannot drain

module link_session_lifecycle_fsm_unit import lslf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lslf_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lslf_rsp_t out_rsp_o
);

  // input beat register
  logic      in_vld_q, in_vld_d;
  lslf_req_t in_req_q;

  // result register
  logic      out_vld_q, out_vld_d;
  lslf_rsp_t out_rsp_q;

  lslf_rsp_t core_rsp;
  logic      out_free;   // result register can take a beat this cycle
  logic      fire;       // beat moves from input register to result register
  logic      in_take;    // input beat accepted

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_take || (in_vld_q && !fire);
  assign out_vld_d = fire || (out_vld_q && out_stall_i);

  lslf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_req_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) in_req_q <= in_req_i;
    if (fire) out_rsp_q <= core_rsp;
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

  // a held input beat drains whenever the result register has room
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_free) |=> out_vld_q)
    else $error("input beat did not reach result register");

  // a result appears only after a beat was waiting in the input register
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("result without input beat");

  // close success always lands in closed
  a_close_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_rsp_q.action == ACT_CLOSE_OK) |-> out_rsp_q.state_now == SC_CLOSED)
    else $error("close_ok reported outside closed");

  // finalized never carries an action
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_rsp_q.state_now == SC_FINALIZED) |-> out_rsp_q.action == ACT_NONE)
    else $error("action issued in finalized");

endmodule

@@ sv/lslf_core.sv @@
// lslf_core: session state and finalize flag registers with the transition
// table; depends on lslf_pkg

module lslf_core import lslf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  lslf_req_t req_i,
  output lslf_rsp_t rsp_o
);

  lslf_state_e state_q, state_d;
  logic        fin_q, fin_d;
  logic        fin_eff;
  logic        go;
  lslf_act_e   act;
  logic [3:0]  ev;

  assign ev      = req_i.req_type;
  assign fin_eff = fin_q | req_i.finalize_request;

  always_comb begin
    state_d = state_q;
    act     = ACT_NONE;
    go      = 1'b0;
    if (ev == EV_SESSION_RST) begin
      state_d = (state_q == ST_NOT_PRESENT) ? ST_NOT_PRESENT : ST_IDLE;
      go      = 1'b1;
    end else begin
      case (state_q)
        ST_NOT_PRESENT: begin
          if (ev == EV_API_OPEN) act = ACT_OPEN_FAIL;
          if (ev == EV_API_CLOSE) act = ACT_CLOSE_FAIL;
        end
        ST_IDLE: begin
          if (ev == EV_API_OPEN) begin
            state_d = ST_LL_OPENING;
            go      = 1'b1;
          end
        end
        ST_LL_OPENING: begin
          if (ev == EV_OPEN_ACK) begin
            state_d = ST_BULK_OPENING;
            go      = 1'b1;
          end else if (ev == EV_OPEN_NACK || ev == EV_API_CLOSE) begin
            state_d = ST_LL_CLOSING;
            go      = 1'b1;
          end
        end
        ST_BULK_OPENING: begin
          if (ev == EV_BULK_ACK) begin
            state_d = ST_LINK_RESYNC;
            go      = 1'b1;
          end else if (ev == EV_BULK_NACK || ev == EV_API_CLOSE) begin
            state_d = ST_LL_CLOSING;
            go      = 1'b1;
          end
        end
        ST_LINK_RESYNC: begin
          if (ev == EV_RST_REQ) begin
            act = ACT_RST_ACK;
          end else if (ev == EV_RST_ACK) begin
            state_d = ST_OPEN;
            act     = ACT_OPEN_OK;
          end else if (ev == EV_API_CLOSE) begin
            state_d = ST_LL_CLOSING;
            go      = 1'b1;
          end
        end
        ST_OPEN: begin
          if (ev == EV_API_CLOSE) begin
            state_d = ST_PUBSUB_FLUSH;
            go      = 1'b1;
          end
        end
        ST_PUBSUB_FLUSH: begin
          if (ev == EV_FLUSH_DONE) begin
            state_d = ST_LINK_DISC;
            go      = 1'b1;
          end
        end
        ST_LINK_DISC: begin
          if (ev == EV_DISC_ACK) begin
            state_d = ST_CLOSE_WAIT;
            go      = 1'b1;
          end
        end
        ST_CLOSE_WAIT: begin
          if (ev == EV_PROCEED) begin
            state_d = ST_LL_CLOSING;
            go      = 1'b1;
          end
        end
        ST_LL_CLOSING: begin
          if (ev == EV_CLOSE_ACK) begin
            if (fin_eff) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_IDLE;
              act     = ACT_CLOSE_OK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign fin_d = fire_i ? fin_eff : fin_q;

  always_comb begin
    rsp_o.action    = go ? entry_action(state_d) : act;
    rsp_o.state_now = state_code(state_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_NO_SESSION;
      fin_q   <= 1'b0;
    end else begin
      if (fire_i) state_q <= state_d;
      fin_q <= fin_d;
    end
  end

endmodule
